// ===== sv/ebcpu_pkg.sv =====
// package for the eight-bit cpu instruction execute core
// holds sizes, opcode field codes and the result struct; no dependencies
`timescale 1ns / 1ps

package ebcpu_pkg;

    localparam int ADDR_BITS   = 14;
    localparam int STACK_DEPTH = 8;
    localparam int SP_BITS     = $clog2(STACK_DEPTH);
    localparam int NUM_REGS    = 7;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SP_BITS-1:0]   sp_t;

    // memory and io request codes as they appear on the result channel
    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READ  = 2'd1,
        MEM_WRITE = 2'd2
    } mem_op_t;

    typedef enum logic [1:0] {
        IO_NONE  = 2'd0,
        IO_READ  = 2'd1,
        IO_WRITE = 2'd2
    } io_op_t;

    typedef enum logic [1:0] {
        SP_HOLD,
        SP_PUSH,
        SP_POP
    } sp_act_t;

    // opcode bits 7..6
    localparam logic [1:0] GRP_MISC = 2'd0;
    localparam logic [1:0] GRP_JUMP = 2'd1;
    localparam logic [1:0] GRP_ALU  = 2'd2;
    localparam logic [1:0] GRP_LOAD = 2'd3;

    // register field values; REG_M selects memory at h:l
    localparam logic [2:0] REG_A = 3'd0;
    localparam logic [2:0] REG_H = 3'd5;
    localparam logic [2:0] REG_L = 3'd6;
    localparam logic [2:0] REG_M = 3'd7;

    // low three opcode bits in the misc group
    localparam logic [2:0] MISC_INR  = 3'd0;
    localparam logic [2:0] MISC_DCR  = 3'd1;
    localparam logic [2:0] MISC_ROT  = 3'd2;
    localparam logic [2:0] MISC_RETC = 3'd3;
    localparam logic [2:0] MISC_ALUI = 3'd4;
    localparam logic [2:0] MISC_RST  = 3'd5;
    localparam logic [2:0] MISC_LDI  = 3'd6;
    localparam logic [2:0] MISC_RET  = 3'd7;

    // low three opcode bits in the jump group (odd values are io)
    localparam logic [2:0] JMP_JC   = 3'd0;
    localparam logic [2:0] JMP_CC   = 3'd2;
    localparam logic [2:0] JMP_JMP  = 3'd4;
    localparam logic [2:0] JMP_CALL = 3'd6;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_ADC = 3'd1;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_SBB = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CMP = 3'd7;

    localparam logic [2:0] ROT_RLC = 3'd0;
    localparam logic [2:0] ROT_RRC = 3'd1;
    localparam logic [2:0] ROT_RAL = 3'd2;
    localparam logic [2:0] ROT_RAR = 3'd3;

    localparam logic [7:0] OP_HLT_FF = 8'hFF;

    typedef struct packed {
        addr_t    next_pc;
        logic [7:0] accumulator;
        logic [3:0] flags;
        logic     halted;
        mem_op_t  mem_op;
        addr_t    mem_addr;
        logic [7:0] mem_write_data;
        io_op_t   io_op;
        logic [4:0] io_port;
        logic [3:0] cycles;
        logic     illegal;
    } result_t;

endpackage

// ===== sv/ebcpu_instr_if.sv =====
// instruction channel: valid/ready handshake with the instruction payload
// depends on ebcpu_pkg
`timescale 1ns / 1ps

interface ebcpu_instr_if;
    import ebcpu_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] mem_read_data;
    logic [7:0] io_read_data;
    logic       from_interrupt;

    modport source (
        output valid, opcode, operand_low, operand_high,
               mem_read_data, io_read_data, from_interrupt,
        input  ready
    );

    modport sink (
        input  valid, opcode, operand_low, operand_high,
               mem_read_data, io_read_data, from_interrupt,
        output ready
    );
endinterface

// ===== sv/ebcpu_result_if.sv =====
// result channel: valid/ready handshake with the execution result payload
// depends on ebcpu_pkg
`timescale 1ns / 1ps

interface ebcpu_result_if;
    import ebcpu_pkg::*;

    logic       valid;
    logic       ready;
    addr_t      next_pc;
    logic [7:0] accumulator;
    logic [3:0] flags;
    logic       halted;
    logic [1:0] mem_op;
    addr_t      mem_addr;
    logic [7:0] mem_write_data;
    logic [1:0] io_op;
    logic [4:0] io_port;
    logic [3:0] cycles;
    logic       illegal;

    modport source (
        output valid, next_pc, accumulator, flags, halted, mem_op, mem_addr,
               mem_write_data, io_op, io_port, cycles, illegal,
        input  ready
    );

    modport sink (
        input  valid, next_pc, accumulator, flags, halted, mem_op, mem_addr,
               mem_write_data, io_op, io_port, cycles, illegal,
        output ready
    );
endinterface

// ===== sv/eight_bit_cpu_instruction_execute_core.sv =====
// the result is registered and valid in the cycle after the instruction transaction
// throughput: one instruction per cycle while results are taken; decode, alu and stack update fit one stage
// a new instruction is taken when the result register is empty or drains in the same cycle
// reset clears registers, flags, address stack, stack pointer and halt
// depends on ebcpu_pkg, ebcpu_instr_if, ebcpu_result_if
`timescale 1ns / 1ps

module eight_bit_cpu_instruction_execute_core (
    input  logic           clk,
    input  logic           rst_n,
    ebcpu_instr_if.sink    instr,
    ebcpu_result_if.source result
);
    import ebcpu_pkg::*;

    // architectural state
    logic [7:0] rf_reg [0:NUM_REGS-1];
    addr_t      stack_reg [0:STACK_DEPTH-1];
    addr_t      pc_reg;
    sp_t        sp_reg;
    logic       cy_reg, z_reg, s_reg, p_reg;
    logic       halt_reg;

    result_t    result_reg, result_next;
    logic       out_valid_reg;
    logic       in_fire;

    logic [7:0] op, lo, a_val, src_val, incdec;
    logic [1:0] grp;
    logic [2:0] r1, r2, src_idx;
    addr_t      hl, target, pc_fetch, v0, push_pc, pc_out, rst_vec;
    sp_t        sp_below;
    logic       irq, cond_ok, cond_flag;
    logic [8:0] alu_t;
    logic       alu_carry;

    logic       rf_we;
    logic [2:0] rf_wa;
    logic [7:0] rf_wd;
    logic       szp_we, cy_we, cy_val, halt_next;
    logic [7:0] szp_val;
    sp_act_t    sp_act;
    mem_op_t    mop;
    io_op_t     iop;
    logic [7:0] mdata;
    logic [4:0] port;
    logic [3:0] cyc;
    logic       ill;
    logic       cy_new, z_new, s_new, p_new;

    assign instr.ready = !out_valid_reg || result.ready;
    assign in_fire     = instr.valid && instr.ready;

    assign op       = instr.opcode;
    assign lo       = instr.operand_low;
    assign irq      = instr.from_interrupt;
    assign grp      = op[7:6];
    assign r1       = op[5:3];
    assign r2       = op[2:0];
    assign a_val    = rf_reg[REG_A];
    assign hl       = {rf_reg[REG_H][5:0], rf_reg[REG_L]};
    assign target   = {instr.operand_high[5:0], lo};
    assign rst_vec  = {{(ADDR_BITS-6){1'b0}}, op[5:3], 3'd0};
    assign sp_below = sp_reg - sp_t'(1);

    // a halted core resumes at pc+1 on an interrupt; interrupts otherwise keep pc
    assign pc_fetch = (irq && !halt_reg) ? pc_reg : pc_reg + addr_t'(1);

    // inc/dec read the destination field, everything else the source field
    assign src_idx = (grp == GRP_MISC && r2[2:1] == 2'b00) ? r1 : r2;
    assign src_val = (src_idx == REG_M) ? instr.mem_read_data : rf_reg[src_idx];
    assign incdec  = (r2 == MISC_INR) ? src_val + 8'd1 : src_val - 8'd1;

    always_comb
    begin
        unique case (r1[1:0])
            2'd0: cond_flag = cy_reg;
            2'd1: cond_flag = z_reg;
            2'd2: cond_flag = s_reg;
            default: cond_flag = p_reg;
        endcase
        cond_ok = (cond_flag == op[5]);
    end

    always_comb
    begin
        logic [7:0] b;
        b = (grp == GRP_MISC) ? lo : src_val;
        unique case (r1)
            ALU_ADD: alu_t = {1'b0, a_val} + {1'b0, b};
            ALU_ADC: alu_t = {1'b0, a_val} + {1'b0, b} + {8'd0, cy_reg};
            ALU_SUB, ALU_CMP: alu_t = {1'b0, a_val} - {1'b0, b};
            ALU_SBB: alu_t = {1'b0, a_val} - {1'b0, b} - {8'd0, cy_reg};
            ALU_AND: alu_t = {1'b0, a_val & b};
            ALU_XOR: alu_t = {1'b0, a_val ^ b};
            default: alu_t = {1'b0, a_val | b};
        endcase
        alu_carry = (r1 == ALU_AND || r1 == ALU_XOR || r1 == ALU_OR) ? 1'b0 : alu_t[8];
    end

    always_comb
    begin
        rf_we     = 1'b0;
        rf_wa     = REG_A;
        rf_wd     = alu_t[7:0];
        szp_we    = 1'b0;
        szp_val   = alu_t[7:0];
        cy_we     = 1'b0;
        cy_val    = alu_carry;
        v0        = pc_fetch;
        sp_act    = SP_HOLD;
        push_pc   = target;
        halt_next = irq ? 1'b0 : halt_reg;
        mop       = MEM_NONE;
        mdata     = 8'd0;
        iop       = IO_NONE;
        port      = 5'd0;
        cyc       = 4'd5;
        ill       = 1'b0;

        unique case (grp)
            GRP_LOAD:
            begin
                if (op == OP_HLT_FF)
                begin
                    cyc       = 4'd4;
                    v0        = pc_fetch - addr_t'(1);
                    halt_next = 1'b1;
                end
                else
                begin
                    if (r2 == REG_M)
                    begin
                        cyc = 4'd8;
                        mop = MEM_READ;
                    end
                    if (r1 == REG_M)
                    begin
                        cyc   = 4'd7;
                        mop   = MEM_WRITE;
                        mdata = src_val;
                    end
                    else
                    begin
                        rf_we = 1'b1;
                        rf_wa = r1;
                        rf_wd = src_val;
                    end
                end
            end
            GRP_MISC:
            begin
                unique case (r2)
                    MISC_INR, MISC_DCR:
                    begin
                        if (r1 == REG_A)
                        begin
                            cyc       = 4'd4;
                            v0        = pc_fetch - addr_t'(1);
                            halt_next = 1'b1;
                        end
                        else if (r1 == REG_M)
                        begin
                            ill = 1'b1;
                        end
                        else
                        begin
                            rf_we   = 1'b1;
                            rf_wa   = r1;
                            rf_wd   = incdec;
                            szp_we  = 1'b1;
                            szp_val = incdec;
                        end
                    end
                    MISC_ROT:
                    begin
                        unique case (r1)
                            ROT_RLC:
                            begin
                                rf_we  = 1'b1;
                                rf_wd  = {a_val[6:0], a_val[7]};
                                cy_we  = 1'b1;
                                cy_val = a_val[7];
                            end
                            ROT_RRC:
                            begin
                                rf_we  = 1'b1;
                                rf_wd  = {a_val[0], a_val[7:1]};
                                cy_we  = 1'b1;
                                cy_val = a_val[0];
                            end
                            ROT_RAL:
                            begin
                                rf_we  = 1'b1;
                                rf_wd  = {a_val[6:0], cy_reg};
                                cy_we  = 1'b1;
                                cy_val = a_val[7];
                            end
                            ROT_RAR:
                            begin
                                rf_we  = 1'b1;
                                rf_wd  = {cy_reg, a_val[7:1]};
                                cy_we  = 1'b1;
                                cy_val = a_val[0];
                            end
                            default: ill = 1'b1;
                        endcase
                    end
                    MISC_RETC:
                    begin
                        cyc = 4'd3;
                        if (cond_ok)
                        begin
                            cyc    = 4'd5;
                            sp_act = SP_POP;
                        end
                    end
                    MISC_ALUI:
                    begin
                        cyc    = 4'd8;
                        v0     = pc_fetch + addr_t'(1);
                        szp_we = 1'b1;
                        cy_we  = 1'b1;
                        rf_we  = (r1 != ALU_CMP);
                    end
                    MISC_RST:
                    begin
                        sp_act  = SP_PUSH;
                        push_pc = rst_vec;
                    end
                    MISC_LDI:
                    begin
                        cyc = 4'd8;
                        v0  = pc_fetch + addr_t'(1);
                        if (r1 == REG_M)
                        begin
                            cyc   = 4'd9;
                            mop   = MEM_WRITE;
                            mdata = lo;
                        end
                        else
                        begin
                            rf_we = 1'b1;
                            rf_wa = r1;
                            rf_wd = lo;
                        end
                    end
                    default: sp_act = SP_POP;
                endcase
            end
            GRP_JUMP:
            begin
                unique case (r2)
                    JMP_JC:
                    begin
                        cyc = 4'd9;
                        v0  = pc_fetch + addr_t'(2);
                        if (cond_ok)
                        begin
                            cyc = 4'd11;
                            v0  = target;
                        end
                    end
                    JMP_CC:
                    begin
                        cyc = 4'd9;
                        v0  = pc_fetch + addr_t'(2);
                        if (cond_ok)
                        begin
                            cyc    = 4'd11;
                            sp_act = SP_PUSH;
                        end
                    end
                    JMP_JMP:
                    begin
                        cyc = 4'd11;
                        v0  = target;
                    end
                    JMP_CALL:
                    begin
                        cyc    = 4'd11;
                        v0     = pc_fetch + addr_t'(2);
                        sp_act = SP_PUSH;
                    end
                    default:
                    begin
                        port = op[5:1];
                        if (op[5:4] == 2'b00)
                        begin
                            cyc   = 4'd8;
                            iop   = IO_READ;
                            rf_we = 1'b1;
                            rf_wd = instr.io_read_data;
                        end
                        else
                        begin
                            cyc = 4'd6;
                            iop = IO_WRITE;
                        end
                    end
                endcase
            end
            default:
            begin
                if (r2 == REG_M)
                begin
                    cyc = 4'd8;
                    mop = MEM_READ;
                end
                szp_we = 1'b1;
                cy_we  = 1'b1;
                rf_we  = (r1 != ALU_CMP);
            end
        endcase
    end

    always_comb
    begin
        unique case (sp_act)
            SP_PUSH: pc_out = push_pc;
            SP_POP:  pc_out = stack_reg[sp_below];
            default: pc_out = v0;
        endcase
    end

    assign cy_new = cy_we ? cy_val : cy_reg;
    assign z_new  = szp_we ? (szp_val == 8'd0) : z_reg;
    assign s_new  = szp_we ? szp_val[7] : s_reg;
    assign p_new  = szp_we ? ~(^szp_val) : p_reg;

    always_comb
    begin
        result_next.next_pc        = pc_out;
        result_next.accumulator    = (rf_we && rf_wa == REG_A) ? rf_wd : a_val;
        result_next.flags          = {cy_new, z_new, s_new, p_new};
        result_next.halted         = halt_next;
        result_next.mem_op         = mop;
        result_next.mem_addr       = (mop != MEM_NONE) ? hl : '0;
        result_next.mem_write_data = mdata;
        result_next.io_op          = iop;
        result_next.io_port        = port;
        result_next.cycles         = cyc;
        result_next.illegal        = ill;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= 8'd0;
            end
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stack_reg[i] <= '0;
            end
            pc_reg        <= '0;
            sp_reg        <= '0;
            cy_reg        <= 1'b0;
            z_reg         <= 1'b0;
            s_reg         <= 1'b0;
            p_reg         <= 1'b0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (rf_we)
                begin
                    rf_reg[rf_wa] <= rf_wd;
                end
                // the slot at the current pointer always keeps this level's pc
                stack_reg[sp_reg] <= v0;
                pc_reg   <= pc_out;
                cy_reg   <= cy_new;
                z_reg    <= z_new;
                s_reg    <= s_new;
                p_reg    <= p_new;
                halt_reg <= halt_next;
                unique case (sp_act)
                    SP_PUSH: sp_reg <= sp_reg + sp_t'(1);
                    SP_POP:  sp_reg <= sp_below;
                    default: sp_reg <= sp_reg;
                endcase
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.next_pc        = result_reg.next_pc;
    assign result.accumulator    = result_reg.accumulator;
    assign result.flags          = result_reg.flags;
    assign result.halted         = result_reg.halted;
    assign result.mem_op         = result_reg.mem_op;
    assign result.mem_addr       = result_reg.mem_addr;
    assign result.mem_write_data = result_reg.mem_write_data;
    assign result.io_op          = result_reg.io_op;
    assign result.io_port        = result_reg.io_port;
    assign result.cycles         = result_reg.cycles;
    assign result.illegal        = result_reg.illegal;

endmodule

// ===== sv/ebcpu_checker.sv =====
// port-level checks for the execute core, attached by bind
// depends on ebcpu_pkg and eight_bit_cpu_instruction_execute_core
`timescale 1ns / 1ps

module ebcpu_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [ebcpu_pkg::ADDR_BITS-1:0] next_pc,
    input logic [1:0]             mem_op,
    input logic [1:0]             io_op,
    input logic [4:0]             io_port,
    input logic [3:0]             cycles,
    input logic                   illegal
);
    import ebcpu_pkg::*;

    // a stalled result stays valid and holds next_pc and cycles
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(cycles))
        else $error("result changed while stalled");

    // the result register never blocks the input side once it drains
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled with free result slot");

    // every accepted instruction shows a result in the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("result missing one cycle after transaction");

    // an ignored opcode makes no memory or io request, leaves io_port at zero and reports a cycles field of five
    a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && illegal |-> mem_op == MEM_NONE && io_op == IO_NONE
                                 && io_port == 5'd0 && cycles == 4'd5)
        else $error("illegal opcode had side effects");

endmodule

bind eight_bit_cpu_instruction_execute_core ebcpu_checker u_ebcpu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (instr.valid),
    .in_ready  (instr.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .next_pc   (result.next_pc),
    .mem_op    (result.mem_op),
    .io_op     (result.io_op),
    .io_port   (result.io_port),
    .cycles    (result.cycles),
    .illegal   (result.illegal)
);
